### sv/jsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared types, constants and helper functions of the julia set pixel colorer.
// ----------------------------------------------------------------------------
package jsc_pkg;

   localparam int SCREEN_WIDTH  = 480;
   localparam int SCREEN_HEIGHT = 320;
   localparam int FRAC_BITS     = 28;
   localparam int ITER_LIMIT    = 1023;

   localparam int FX_W    = 32;
   localparam int PROD_W  = 2 * FX_W;
   localparam int SQ_W    = PROD_W - FRAC_BITS;
   localparam int SUM_W   = SQ_W + 2;
   localparam int ITER_W  = 10;
   localparam int PIX_W   = 9;
   localparam int COLOR_W = 16;
   localparam int IDX_W   = 3;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_C_REAL   = 3'd0;
   localparam logic [IDX_W-1:0] CSR_C_IMAG   = 3'd1;
   localparam logic [IDX_W-1:0] CSR_SHIFT_X  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_SHIFT_Y  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_MAX_ITER = 3'd4;

   localparam logic signed [FX_W-1:0] C_REAL_RST   = -32'sd187904819;
   localparam logic signed [FX_W-1:0] C_IMAG_RST   = 32'sd72518324;
   localparam logic [ITER_W-1:0]      MAX_ITER_RST = 10'd200;

   localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
   localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] ESC_BOUND = SUM_W'(64'd4 << FRAC_BITS);

   // pixel step is 3*2^F/480 = 2*2^F/320 = 2^23/5 on both axes
   localparam int STEP_DEN   = 5;
   localparam int STEP_SHIFT = 23;
   localparam int RECIP      = 205;
   localparam int RECIP_SH   = 10;
   localparam int X_CENTER_Q = SCREEN_WIDTH / 2 / STEP_DEN;
   localparam int Y_CENTER_Q = SCREEN_HEIGHT / 2 / STEP_DEN;
   localparam logic [STEP_SHIFT-1:0] FRAC_R1 = STEP_SHIFT'((64'd1 << STEP_SHIFT) * 1 / STEP_DEN);
   localparam logic [STEP_SHIFT-1:0] FRAC_R2 = STEP_SHIFT'((64'd1 << STEP_SHIFT) * 2 / STEP_DEN);
   localparam logic [STEP_SHIFT-1:0] FRAC_R3 = STEP_SHIFT'((64'd1 << STEP_SHIFT) * 3 / STEP_DEN);
   localparam logic [STEP_SHIFT-1:0] FRAC_R4 = STEP_SHIFT'((64'd1 << STEP_SHIFT) * 4 / STEP_DEN);

   typedef logic signed [FX_W-1:0] fx_type;
   typedef logic signed [SQ_W-1:0] sq_type;

   typedef struct packed {
      fx_type              c_real;
      fx_type              c_imag;
      fx_type              shift_x;
      fx_type              shift_y;
      logic [ITER_W-1:0]   max_iter;
   } cfg_type;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SQR  = 6'b000010,
      S_SQI  = 6'b000100,
      S_CHK  = 6'b001000,
      S_MRI  = 6'b010000,
      S_UPD  = 6'b100000
   } state_type;

   function automatic fx_type sat_fx(input logic signed [SUM_W+1:0] v);
      if (v > (SUM_W+2)'(FX_MAX)) begin
         return FX_MAX;
      end else if (v < (SUM_W+2)'(FX_MIN)) begin
         return FX_MIN;
      end
      return FX_W'(v);
   endfunction

   // floor((p - center) * 2^23 / 5) + shift, saturated
   function automatic fx_type start_coord(input logic [PIX_W-1:0] p,
                                          input logic [6:0] center_q,
                                          input fx_type shift);
      logic [17:0]            prod;
      logic [6:0]             q;
      logic [2:0]             r;
      logic signed [7:0]      qs;
      logic [STEP_SHIFT-1:0]  fr;
      logic signed [33:0]     sum;
      prod = 18'(p) * 18'(RECIP);
      q    = prod[RECIP_SH+6:RECIP_SH];
      r    = 3'(p - 9'(9'(q) * 9'(STEP_DEN)));
      qs   = $signed({1'b0, q}) - $signed({1'b0, center_q});
      case (r)
         3'd1:    fr = FRAC_R1;
         3'd2:    fr = FRAC_R2;
         3'd3:    fr = FRAC_R3;
         3'd4:    fr = FRAC_R4;
         default: fr = '0;
      endcase
      sum = (34'(qs) <<< STEP_SHIFT) + $signed(34'(fr)) + 34'(shift);
      return sat_fx((SUM_W+2)'(sum));
   endfunction

   function automatic logic [COLOR_W-1:0] hue_color(input logic [7:0] h);
      logic [10:0] h6;
      logic [2:0]  sector;
      logic [7:0]  f;
      logic [16:0] fall_arg;
      logic [16:0] rise_arg;
      logic [31:0] fall_prod;
      logic [31:0] rise_prod;
      logic [7:0]  qq;
      logic [7:0]  tt;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      h6        = 11'(h) * 11'd6;
      sector    = h6[10:8];
      f         = h6[7:0];
      fall_arg  = 17'd65536 - 17'(17'd255 * 17'(f));
      rise_arg  = 17'd65536 - 17'(17'd255 * (17'd256 - 17'(f)));
      fall_prod = 32'd65025 * 32'(fall_arg);
      rise_prod = 32'd65025 * 32'(rise_arg);
      qq        = fall_prod[31:24];
      tt        = rise_prod[31:24];
      case (sector)
         3'd0:    begin r = 8'd254; g = tt;     b = 8'd0;   end
         3'd1:    begin r = qq;     g = 8'd254; b = 8'd0;   end
         3'd2:    begin r = 8'd0;   g = 8'd254; b = tt;     end
         3'd3:    begin r = 8'd0;   g = qq;     b = 8'd254; end
         3'd4:    begin r = tt;     g = 8'd0;   b = 8'd254; end
         default: begin r = 8'd254; g = 8'd0;   b = qq;     end
      endcase
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

### sv/jsc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsc_csr
// Configuration registers: julia constant, view offset and iteration limit.
// ----------------------------------------------------------------------------
module jsc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [jsc_pkg::IDX_W-1:0]   csr_index,
   input  logic [jsc_pkg::FX_W-1:0]    csr_wdata,
   output jsc_pkg::cfg_type            cfg
);
   import jsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_C_REAL:   cfg_in.c_real   = $signed(csr_wdata);
            CSR_C_IMAG:   cfg_in.c_imag   = $signed(csr_wdata);
            CSR_SHIFT_X:  cfg_in.shift_x  = $signed(csr_wdata);
            CSR_SHIFT_Y:  cfg_in.shift_y  = $signed(csr_wdata);
            CSR_MAX_ITER: cfg_in.max_iter = csr_wdata[ITER_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_real   <= C_REAL_RST;
         cfg_ff.c_imag   <= C_IMAG_RST;
         cfg_ff.shift_x  <= '0;
         cfg_ff.shift_y  <= '0;
         cfg_ff.max_iter <= MAX_ITER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/jsc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsc_mul
// Shared signed fixed point multiplier, registered, result floored to the
// fraction width.
// ----------------------------------------------------------------------------
module jsc_mul (
   input  logic              clock,
   input  jsc_pkg::fx_type   mul_a,
   input  jsc_pkg::fx_type   mul_b,
   output jsc_pkg::sq_type   mul_q
);
   import jsc_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   // dropping the low bits of a two's complement product is a floor
   assign mul_q   = prod_ff[PROD_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### sv/jsc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsc_core
// Escape time sequencer: start point, iteration z = z*z + c on the shared
// multiplier, escape test and coloring.
// ----------------------------------------------------------------------------
module jsc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [jsc_pkg::PIX_W-1:0]     req_pixel_x,
   input  logic [jsc_pkg::PIX_W-1:0]     req_pixel_y,
   output logic                          rsp_valid,
   output logic [jsc_pkg::COLOR_W-1:0]   rsp_color,
   output logic [jsc_pkg::ITER_W-1:0]    rsp_iter_count,
   input  jsc_pkg::cfg_type              cfg
);
   import jsc_pkg::*;

   state_type           state_ff, state_in;
   fx_type              re_ff, re_in;
   fx_type              im_ff, im_in;
   sq_type              rr_ff, rr_in;
   sq_type              ii_ff, ii_in;
   logic [ITER_W-1:0]   n_ff, n_in;
   logic [ITER_W-1:0]   limit_ff, limit_in;
   logic                first_ff, first_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic [ITER_W-1:0]   rsp_count_ff, rsp_count_in;

   fx_type              mul_a;
   fx_type              mul_b;
   sq_type              mul_q;
   logic [ITER_W-1:0]   eff_limit;
   logic signed [SUM_W-1:0] mag;
   logic                escaped;

   jsc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_q (mul_q)
   );

   always_comb begin
      case (state_ff)
         S_SQI:   begin mul_a = im_ff; mul_b = im_ff; end
         S_MRI:   begin mul_a = re_ff; mul_b = im_ff; end
         default: begin mul_a = re_ff; mul_b = re_ff; end
      endcase
   end

   assign eff_limit = (32'(cfg.max_iter) > ITER_LIMIT) ? ITER_W'(ITER_LIMIT) : cfg.max_iter;
   assign mag       = SUM_W'(rr_ff) + SUM_W'(mul_q);
   assign escaped   = mag > ESC_BOUND;

   always_comb begin
      state_in     = state_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      n_in         = n_ff;
      limit_in     = limit_ff;
      first_in     = first_ff;
      rsp_valid_in = 1'b0;
      rsp_color_in = rsp_color_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               re_in    = start_coord(req_pixel_x, 7'(X_CENTER_Q), cfg.shift_x);
               im_in    = start_coord(req_pixel_y, 7'(Y_CENTER_Q), cfg.shift_y);
               n_in     = '0;
               limit_in = eff_limit;
               first_in = 1'b1;
               if (eff_limit == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_color_in = '0;
                  rsp_count_in = '0;
               end else begin
                  state_in = S_SQR;
               end
            end
         end
         S_SQR: begin
            state_in = S_SQI;
         end
         S_SQI: begin
            rr_in    = mul_q;
            state_in = S_CHK;
         end
         S_CHK: begin
            ii_in = mul_q;
            if (first_ff) begin
               first_in = 1'b0;
               state_in = S_MRI;
            end else if (escaped) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = hue_color(n_ff[7:0]);
               rsp_count_in = n_ff;
               state_in     = S_IDLE;
            end else if (n_ff + 1'b1 == limit_ff) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = '0;
               rsp_count_in = limit_ff;
               state_in     = S_IDLE;
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = S_MRI;
            end
         end
         S_MRI: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            re_in    = sat_fx((SUM_W+2)'(rr_ff) - (SUM_W+2)'(ii_ff) + (SUM_W+2)'(cfg.c_real));
            im_in    = sat_fx(((SUM_W+2)'(mul_q) <<< 1) + (SUM_W+2)'(cfg.c_imag));
            state_in = S_SQR;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
         n_ff         <= '0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         n_ff         <= n_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      re_ff        <= re_in;
      im_ff        <= im_in;
      rr_ff        <= rr_in;
      ii_ff        <= ii_in;
      rsp_color_ff <= rsp_color_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_color      = rsp_color_ff;
   assign rsp_iter_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted word neither started nor answered");

   a_rsp_after_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE && ($past(state_ff) == S_CHK || $past(state_ff) == S_IDLE))
      else $error("result strobe outside check exit");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_iter_count <= limit_ff)
      else $error("iteration count above limit");

   a_black_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_color == '0 |-> rsp_iter_count == limit_ff)
      else $error("black pixel that escaped");

   a_counter_in_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> n_ff < limit_ff)
      else $error("iteration counter ran past limit");
`endif

endmodule

### sv/julia_set_pixel_color_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_set_pixel_color_top
// Julia set escape time pixel colorer with RGB565 hue output.
// ----------------------------------------------------------------------------
// A pixel word is taken when start is high and busy is low; unless max_iter
// is zero, busy then stays high until the result strobe. One 32x32
// multiplier, used three times per iteration, sets the pace: the start point
// is squared first, then each iteration forms the cross product, updates z,
// squares both parts and tests for escape. A max_iter of zero answers black
// with a count of zero and no iteration. rsp_valid is high for exactly one
// cycle per pixel and the receiver cannot stall it; a new pixel may be
// started in that same cycle. The user must write configuration only
// while busy is low and no result is pending; the block does not enforce it.
// ----------------------------------------------------------------------------
module julia_set_pixel_color_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [jsc_pkg::PIX_W-1:0]     req_pixel_x,
   input  logic [jsc_pkg::PIX_W-1:0]     req_pixel_y,
   output logic                          rsp_valid,
   output logic [jsc_pkg::COLOR_W-1:0]   rsp_color,
   output logic [jsc_pkg::ITER_W-1:0]    rsp_iter_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [jsc_pkg::IDX_W-1:0]     csr_index,
   input  logic [jsc_pkg::FX_W-1:0]      csr_wdata
);
   import jsc_pkg::*;

   cfg_type cfg;

   jsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jsc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_color      (rsp_color),
      .rsp_iter_count (rsp_iter_count),
      .cfg            (cfg)
   );

endmodule

### bench/julia_set_pixel_color_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_set_pixel_color_checker
// Watches the pixel, result and register channels of the julia set colorer.
// Every accepted pixel word is run through a fixed point escape time model
// with its own copy of the registers. Each result word is then compared field
// by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module julia_set_pixel_color_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [jsc_pkg::PIX_W-1:0]     req_pixel_x,
   input  logic [jsc_pkg::PIX_W-1:0]     req_pixel_y,
   input  logic                          rsp_valid,
   input  logic [jsc_pkg::COLOR_W-1:0]   rsp_color,
   input  logic [jsc_pkg::ITER_W-1:0]    rsp_iter_count,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [jsc_pkg::IDX_W-1:0]     csr_index,
   input  logic [jsc_pkg::FX_W-1:0]      csr_wdata,
   output int                            fail_count,
   output int                            pending
);
   import jsc_pkg::*;

   typedef struct {
      logic [COLOR_W-1:0] color;
      logic [ITER_W-1:0]  iter_count;
   } pixel_word_type;

   // registers are already in the working format, so no alignment is needed
   localparam longint Q_ONE = longint'(1) << FRAC_BITS;
   localparam longint Q_MAX = (longint'(1) << (FRAC_BITS + 3)) - 1;
   localparam longint Q_MIN = -(longint'(1) << (FRAC_BITS + 3));

   fx_type            c_re;
   fx_type            c_im;
   fx_type            off_x;
   fx_type            off_y;
   logic [ITER_W-1:0] iter_limit;
   pixel_word_type    expected_pixels[$];

   function automatic longint clamp_q4(input longint v);
      if (v > Q_MAX) begin
         return Q_MAX;
      end
      if (v < Q_MIN) begin
         return Q_MIN;
      end
      return v;
   endfunction

   function automatic longint div_floor(input longint num, input longint den);
      if (num >= 0) begin
         return num / den;
      end
      return -((-num + den - 1) / den);
   endfunction

   // exact product floored to the fraction width
   function automatic longint mul_q(input longint a, input longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic logic [COLOR_W-1:0] hue_rgb565(input int unsigned count);
      longint h6;
      longint f;
      longint fall;
      longint rise;
      longint r;
      longint g;
      longint b;
      h6   = longint'(count % 256) * 6;
      f    = h6 % 256;
      fall = (longint'(65025) * (longint'(65536) - 255 * f)) >>> 24;
      rise = (longint'(65025) * (longint'(65536) - 255 * (256 - f))) >>> 24;
      case (h6 / 256)
         0: begin r = 254;  g = rise; b = 0;    end
         1: begin r = fall; g = 254;  b = 0;    end
         2: begin r = 0;    g = 254;  b = rise; end
         3: begin r = 0;    g = fall; b = 254;  end
         4: begin r = rise; g = 0;    b = 254;  end
         default: begin r = 254; g = 0; b = fall; end
      endcase
      return COLOR_W'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
   endfunction

   function automatic pixel_word_type escape_pixel(input logic [PIX_W-1:0] px,
                                                  input logic [PIX_W-1:0] py);
      pixel_word_type w;
      longint         re;
      longint         im;
      longint         nr;
      longint         ni;
      int unsigned    lim;
      int unsigned    n;
      logic           escaped;
      re = clamp_q4(div_floor((longint'(px) - longint'(SCREEN_WIDTH / 2)) * 3 * Q_ONE,
                              longint'(SCREEN_WIDTH)) + longint'(off_x));
      im = clamp_q4(div_floor((longint'(py) - longint'(SCREEN_HEIGHT / 2)) * 2 * Q_ONE,
                              longint'(SCREEN_HEIGHT)) + longint'(off_y));
      lim = (int'(iter_limit) > ITER_LIMIT) ? ITER_LIMIT : int'(iter_limit);
      n = 0;
      escaped = 1'b0;
      while (!escaped && n < lim) begin
         nr = clamp_q4(mul_q(re, re) - mul_q(im, im) + longint'(c_re));
         ni = clamp_q4(2 * mul_q(re, im) + longint'(c_im));
         re = nr;
         im = ni;
         if (mul_q(re, re) + mul_q(im, im) > 4 * Q_ONE) begin
            escaped = 1'b1;
         end else begin
            n++;
         end
      end
      w.color      = escaped ? hue_rgb565(n) : '0;
      w.iter_count = ITER_W'(n);
      return w;
   endfunction

   always @(posedge clock) begin
      pixel_word_type want;
      if (reset) begin
         c_re       = C_REAL_RST;
         c_im       = C_IMAG_RST;
         off_x      = '0;
         off_y      = '0;
         iter_limit = MAX_ITER_RST;
         expected_pixels.delete();
         pending    = 0;
      end else begin
         // the result leaving at this edge belongs to an older word
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: result word with none expected, color %h iter_count %0d",
                        $time, rsp_color, rsp_iter_count);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_color !== want.color) begin
                  $display("%0t: color expected %h, actual %h", $time, want.color, rsp_color);
                  fail_count++;
               end
               if (rsp_iter_count !== want.iter_count) begin
                  $display("%0t: iter_count expected %0d, actual %0d",
                           $time, want.iter_count, rsp_iter_count);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_pixels.push_back(escape_pixel(req_pixel_x, req_pixel_y));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_C_REAL:   c_re       = csr_wdata;
               CSR_C_IMAG:   c_im       = csr_wdata;
               CSR_SHIFT_X:  off_x      = csr_wdata;
               CSR_SHIFT_Y:  off_y      = csr_wdata;
               CSR_MAX_ITER: iter_limit = csr_wdata[ITER_W-1:0];
               default: ;
            endcase
         end
         pending = expected_pixels.size();
      end
   end

endmodule

### bench/julia_set_pixel_color_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_set_pixel_color_top_tb
// Drives pixel words and register writes into the julia set colorer: a short
// directed pass over screen corners, off screen pixels, a zero and a maximum
// iteration limit and saturating constants, then random phases with fresh
// registers, bursty pixel traffic and drain pauses. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module julia_set_pixel_color_top_tb;
   import jsc_pkg::*;

   localparam int          CYCLE_LIMIT   = 4_000_000;
   localparam int          RANDOM_PHASES = 10;
   localparam int          LAST_INDEX    = (1 << IDX_W) - 1;
   localparam int unsigned Q_ONE         = 1 << FRAC_BITS;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [PIX_W-1:0]   req_pixel_x = '0;
   logic [PIX_W-1:0]   req_pixel_y = '0;
   logic               rsp_valid;
   logic [COLOR_W-1:0] rsp_color;
   logic [ITER_W-1:0]  rsp_iter_count;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [IDX_W-1:0]   csr_index = '0;
   logic [FX_W-1:0]    csr_wdata = '0;
   int                 fail_count;
   int                 pending;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   julia_set_pixel_color_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_color      (rsp_color),
      .rsp_iter_count (rsp_iter_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   julia_set_pixel_color_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_pixel_x    (req_pixel_x),
      .req_pixel_y    (req_pixel_y),
      .rsp_valid      (rsp_valid),
      .rsp_color      (rsp_color),
      .rsp_iter_count (rsp_iter_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // start stays high across back to back words of a burst
   task automatic send_pixel(input int x, input int y);
      @(negedge clock);
      start       = 1'b1;
      req_pixel_x = PIX_W'(x);
      req_pixel_y = PIX_W'(y);
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0 || busy) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input int unsigned index, input logic [FX_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = IDX_W'(index);
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic fx_type rand_fx(input int unsigned span);
      return fx_type'(longint'($urandom_range(0, 2 * span)) - longint'(span));
   endfunction

   function automatic fx_type rand_offset();
      case ($urandom_range(0, 7))
         0:       return fx_type'($urandom);
         1, 2, 3: return '0;
         default: return rand_fx(Q_ONE / 2);
      endcase
   endfunction

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int     p;
      int     i;
      int     items;
      int     burst;
      int     burst_max;
      int     lim;
      fx_type c_r;
      fx_type c_i;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset registers: corners, center, off screen
      send_pixel(0, 0);
      send_pixel(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
      send_pixel(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2);
      send_pixel((1 << PIX_W) - 1, (1 << PIX_W) - 1);
      send_pixel(SCREEN_WIDTH, SCREEN_HEIGHT);
      send_pixel(0, (1 << PIX_W) - 1);
      send_pixel((1 << PIX_W) - 1, 0);
      send_pixel(SCREEN_WIDTH / 2 - 1, SCREEN_HEIGHT / 2 + 1);
      send_pixel(300, 100);
      send_pixel(180, 220);
      drain_results();

      // zero limit answers at once, black
      write_csr(CSR_MAX_ITER, '0);
      send_pixel(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2);
      send_pixel(17, 300);
      drain_results();

      // limit of one with junk above the field
      write_csr(CSR_MAX_ITER, 32'hffff_fc01);
      send_pixel(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2);
      send_pixel(0, 0);
      drain_results();

      // saturating start point and constant
      write_csr(CSR_SHIFT_X, FX_MAX);
      write_csr(CSR_SHIFT_Y, FX_MIN);
      write_csr(CSR_C_REAL, FX_MIN);
      write_csr(CSR_C_IMAG, FX_MAX);
      write_csr(CSR_MAX_ITER, FX_W'(ITER_LIMIT));
      send_pixel(0, 0);
      send_pixel((1 << PIX_W) - 1, (1 << PIX_W) - 1);
      send_pixel(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2);
      drain_results();

      // c of zero keeps small points bounded: limit reached, unknown indexes ignored
      write_csr(CSR_C_REAL, '0);
      write_csr(CSR_C_IMAG, '0);
      write_csr(CSR_SHIFT_X, '0);
      write_csr(CSR_SHIFT_Y, '0);
      write_csr(CSR_MAX_ITER + 1, '1);
      write_csr(LAST_INDEX, $urandom);
      send_pixel(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2);
      send_pixel(SCREEN_WIDTH / 2 + 40, SCREEN_HEIGHT / 2);
      drain_results();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 9))
            0: begin
               c_r = fx_type'($urandom);
               c_i = fx_type'($urandom);
            end
            1: begin
               c_r = $urandom_range(0, 1) ? FX_MAX : FX_MIN;
               c_i = $urandom_range(0, 1) ? FX_MAX : FX_MIN;
            end
            default: begin
               c_r = rand_fx(Q_ONE);
               c_i = rand_fx(Q_ONE);
            end
         endcase
         if (p == 4) begin
            lim   = ITER_LIMIT;
            items = 12;
         end else if (p == 2 || p == 7) begin
            lim   = $urandom_range(200, 300);
            items = 80;
         end else begin
            lim   = $urandom_range(1, 96);
            items = 110;
         end
         write_csr(CSR_C_REAL, c_r);
         write_csr(CSR_C_IMAG, c_i);
         write_csr(CSR_SHIFT_X, rand_offset());
         write_csr(CSR_SHIFT_Y, rand_offset());
         write_csr(CSR_MAX_ITER, ($urandom & ~32'h3ff) | FX_W'(lim));
         if ($urandom_range(0, 1) == 1) begin
            write_csr($urandom_range(CSR_MAX_ITER + 1, LAST_INDEX), $urandom);
         end

         // every third phase draws burst lengths up to the whole phase
         burst_max = (p % 3 == 1) ? items : 12;
         burst     = $urandom_range(1, burst_max);
         for (i = 0; i < items; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               send_pixel($urandom_range(0, (1 << PIX_W) - 1),
                          $urandom_range(0, (1 << PIX_W) - 1));
            end else begin
               send_pixel($urandom_range(0, SCREEN_WIDTH - 1),
                          $urandom_range(0, SCREEN_HEIGHT - 1));
            end
            burst--;
            if ($urandom_range(0, 63) == 0) begin
               drain_results();
            end else if (burst == 0) begin
               hold_off($urandom_range(1, 24));
               burst = $urandom_range(1, burst_max);
            end
         end
         drain_results();
      end

      // catch any stray result word
      repeat (16) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
sv/jsc_pkg.sv
sv/jsc_csr.sv
sv/jsc_mul.sv
sv/jsc_core.sv
sv/julia_set_pixel_color_top.sv
bench/julia_set_pixel_color_checker.sv
bench/julia_set_pixel_color_top_tb.sv
